// ----- rtl/core/gregorian_date_add_days_unit_defines.svh -----
// Assertion macros shared by the date unit modules
`ifndef GREGORIAN_DATE_ADD_DAYS_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset
`define GDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define GDA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/core/gda_pkg.sv -----
// Shared types, calendar tables and a helper function for the date unit
`default_nettype none

package gda_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned DOY_W   = 9;
    // Working day number: largest start day plus largest count
    localparam int unsigned WDAY_W  = 17;
    localparam int unsigned IDX_W   = 3;

    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
    localparam logic [YEAR_W-1:0]  CYCLE_400   = 14'd400;
    localparam logic [YEAR_W-1:0]  CYCLE_LAST  = 14'd399;
    localparam logic [YEAR_W-1:0]  CENTURY_1   = 14'd100;
    localparam logic [YEAR_W-1:0]  CENTURY_2   = 14'd200;
    localparam logic [YEAR_W-1:0]  CENTURY_3   = 14'd300;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP    = 5'd29;
    localparam logic [DAY_W-1:0]   FEB_COMMON  = 5'd28;
    // Restoring steps that reduce a year below 400 (400 << 5 covers 9999)
    localparam logic [IDX_W-1:0]   MOD_TOP_IDX = 3'd5;

    localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [DOY_W-1:0] DAYS_BEFORE [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    localparam logic ACT_ADD_DAYS = 1'b0;
    localparam logic ACT_FROM_DOY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             mod_step;
        logic [IDX_W-1:0] mod_idx;
        logic             walk_step;
        logic             out_load;
    } gda_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic walk_done;
    } gda_stat_t;

    // Length of month m (1..12) in a leap or common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [MONTH_W-1:0] idx;
        idx = m - MONTH_JAN;
        if (m == MONTH_FEB) begin
            month_len = leap ? FEB_LEAP : FEB_COMMON;
        end else begin
            month_len = MONTH_DAYS[idx];
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gda_ctrl.sv -----
// Sequencing state machine for the date unit
`default_nettype none

module gda_ctrl
    import gda_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire gda_stat_t stat,
    output gda_cmd_t       cmd
);

`include "gregorian_date_add_days_unit_defines.svh"

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MOD  = 4'b0010,
        ST_WALK = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             s_accept;
    logic             out_free;

    // Accept only when idle and out of reset
    assign s_tready = (state_reg == ST_IDLE) && aresetn;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Next state and datapath commands
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.mod_idx   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd.load   = 1'b1;
                    idx_next   = MOD_TOP_IDX;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (idx_reg == '0) begin
                    state_next = ST_WALK;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_WALK: begin
                if (stat.walk_done) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result valid until its transfer completes
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `GDA_ASSERT(a_load_free, cmd.out_load |-> (!out_valid_reg || m_tready),
        "result register overwritten before its transfer")
    `GDA_ASSERT(a_accept_mod, s_accept |=> (state_reg == ST_MOD),
        "accepted item did not start year reduction")
    `GDA_ASSERT(a_mod_to_walk, (state_reg == ST_MOD && idx_reg == '0) |=>
        (state_reg == ST_WALK), "year reduction did not hand over to walk")
    `GDA_ASSERT(a_walk_exit, (state_reg == ST_WALK) |=>
        (state_reg == ST_WALK || state_reg == ST_FIN), "walk left to wrong state")

endmodule

`default_nettype wire

// ----- rtl/core/gda_dpath.sv -----
// Date registers, year reduction and month walk datapath
`default_nettype none

module gda_dpath
    import gda_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gda_cmd_t           cmd,
    output gda_stat_t               stat,
    input  wire logic               in_action,
    input  wire logic [YEAR_W-1:0]  in_year,
    input  wire logic [MONTH_W-1:0] in_month,
    input  wire logic [DAY_W-1:0]   in_day,
    input  wire logic [CNT_W-1:0]   day_count,
    output logic [YEAR_W-1:0]       out_year,
    output logic [MONTH_W-1:0]      out_month,
    output logic [DAY_W-1:0]        out_day,
    output logic [DOY_W-1:0]        out_day_of_year
);

`include "gregorian_date_add_days_unit_defines.svh"

    logic [YEAR_W-1:0]  y_reg, y_next;
    logic [MONTH_W-1:0] m_reg, m_next;
    logic [WDAY_W-1:0]  d_reg, d_next;
    // Year modulo 400 once reduced
    logic [YEAR_W-1:0]  rem_reg, rem_next;

    logic [YEAR_W-1:0]  oy_reg;
    logic [MONTH_W-1:0] om_reg;
    logic [DAY_W-1:0]   od_reg;
    logic [DOY_W-1:0]   odoy_reg;

    logic [YEAR_W-1:0]  y_sat;
    logic [MONTH_W-1:0] m_start;
    logic [DAY_W-1:0]   d_start;
    logic [YEAR_W-1:0]  mod_sub;
    logic               leap;
    logic [DAY_W-1:0]   cur_len;
    logic [MONTH_W-1:0] m_idx;
    logic [DOY_W-1:0]   doy;

    // Leap: divisible by 4, and not a century unless divisible by 400
    assign leap = (y_reg[1:0] == 2'b00) &&
                  !(rem_reg == CENTURY_1 || rem_reg == CENTURY_2 || rem_reg == CENTURY_3);
    assign cur_len        = month_len(m_reg, leap);
    assign stat.walk_done = (d_reg <= WDAY_W'(cur_len));
    assign mod_sub        = CYCLE_400 << cmd.mod_idx;
    assign m_idx          = m_reg - MONTH_JAN;
    assign doy = DAYS_BEFORE[m_idx] + DOY_W'(d_reg[DAY_W-1:0])
               + DOY_W'(leap && (m_reg > MONTH_FEB));

    // Clamp the start fields
    always_comb begin
        y_sat   = (in_year > YEAR_MAX) ? YEAR_MAX : in_year;
        m_start = in_month;
        if (in_month < MONTH_JAN) begin
            m_start = MONTH_JAN;
        end else if (in_month > MONTH_DEC) begin
            m_start = MONTH_DEC;
        end
        d_start = (in_day == '0) ? DAY_W'(1) : in_day;
    end

    // Load, reduce the year, then advance one month per step
    always_comb begin
        y_next   = y_reg;
        m_next   = m_reg;
        d_next   = d_reg;
        rem_next = rem_reg;
        if (cmd.load) begin
            y_next   = y_sat;
            rem_next = y_sat;
            if (in_action == ACT_ADD_DAYS) begin
                m_next = m_start;
                d_next = WDAY_W'(d_start) + WDAY_W'(day_count);
            end else begin
                m_next = MONTH_JAN;
                d_next = (day_count == '0) ? WDAY_W'(1) : WDAY_W'(day_count);
            end
        end else if (cmd.mod_step) begin
            if (rem_reg >= mod_sub) begin
                rem_next = rem_reg - mod_sub;
            end
        end else if (cmd.walk_step) begin
            d_next = d_reg - WDAY_W'(cur_len);
            if (m_reg == MONTH_DEC) begin
                m_next   = MONTH_JAN;
                y_next   = y_reg + 1'b1;
                rem_next = (rem_reg == CYCLE_LAST) ? '0 : rem_reg + 1'b1;
            end else begin
                m_next = m_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        y_reg   <= y_next;
        m_reg   <= m_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    // Capture the finished date
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            oy_reg   <= y_reg;
            om_reg   <= m_reg;
            od_reg   <= d_reg[DAY_W-1:0];
            odoy_reg <= doy;
        end
    end

    assign out_year        = oy_reg;
    assign out_month       = om_reg;
    assign out_day         = od_reg;
    assign out_day_of_year = odoy_reg;

    `GDA_ASSERT(a_walk_month, cmd.walk_step |-> (m_reg >= MONTH_JAN && m_reg <= MONTH_DEC),
        "month out of range during walk")
    `GDA_ASSERT(a_walk_rem, cmd.walk_step |-> (rem_reg < CYCLE_400),
        "year residue not reduced before walk")
    `GDA_ASSERT(a_out_day, cmd.out_load |=> (out_day != '0 && out_day_of_year != '0),
        "zero day in finished result")

endmodule

`default_nettype wire

// ----- rtl/core/gregorian_date_add_days_unit.sv -----
// After an input transfer the unit reduces the year, then walks the N month ends crossed (0..~2160),
// and then raises m_tvalid. It takes one item at a time: s_tready is low until the result is loaded.
// The walk retires one month per cycle in a single subtract-and-compare unit,
// after a restoring reduction of the year modulo 400.
// Reset (aresetn low, synchronous) clears the state machine and the result valid flag;
// no clearing pass, s_tready is high as soon as aresetn is high.
`default_nettype none

module gregorian_date_add_days_unit
    import gda_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // in_year[13:0], in_month[17:14], in_day[22:18], day_count[38:23], zero[39]
    input  wire logic [39:0] s_tdata,
    // action[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_year[13:0], out_month[17:14], out_day[22:18], out_day_of_year[31:23]
    output logic [31:0]      m_tdata
);

    gda_cmd_t           cmd;
    gda_stat_t          stat;
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [DOY_W-1:0]   out_day_of_year;

    gda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gda_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_action       (s_tuser[0]),
        .in_year         (s_tdata[13:0]),
        .in_month        (s_tdata[17:14]),
        .in_day          (s_tdata[22:18]),
        .day_count       (s_tdata[38:23]),
        .out_year        (out_year),
        .out_month       (out_month),
        .out_day         (out_day),
        .out_day_of_year (out_day_of_year)
    );

    // Pack the result fields
    assign m_tdata = {out_day_of_year, out_day, out_month, out_year};

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking stream testbench for the Gregorian date add-days unit
`timescale 1ns / 100ps

module tb;
    import gda_pkg::*;

    // Request fields from the lowest bit up: year, month, day, count; action rides in tuser
    typedef struct packed {
        logic        action;
        logic [15:0] cnt;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } date_req_t;

    // Result fields from the lowest bit up: year, month, day, day of year
    typedef struct packed {
        logic [8:0]  doy;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } date_out_t;

    // One directed step: request, whether the answer is written out, and that answer
    typedef struct packed {
        date_req_t req;
        logic      fixed;
        date_out_t want;
    } date_step_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    localparam int NUM_DIRECTED = 23;
    localparam int NUM_RANDOM   = 1950;
    localparam int HOLD_AT_ITEM = 400;
    localparam int HOLD_CYCLES  = 2000;
    localparam int DRAIN_CYCLES = 64;

    // Directed steps; answers given as '{day of year, day, month, year}
    localparam date_step_t DIRECTED_STEPS [NUM_DIRECTED] = '{
        // plain date, no days added
        '{'{ACT_ADD_DAYS, 16'd0, 5'd1, 4'd1, 14'd2000}, 1'b1, '{9'd1, 5'd1, 4'd1, 14'd2000}},
        // year rollover
        '{'{ACT_ADD_DAYS, 16'd1, 5'd31, 4'd12, 14'd1999}, 1'b1,
          '{9'd1, 5'd1, 4'd1, 14'd2000}},
        // leap day in a year divisible by 400
        '{'{ACT_ADD_DAYS, 16'd1, 5'd28, 4'd2, 14'd2000}, 1'b1,
          '{9'd60, 5'd29, 4'd2, 14'd2000}},
        // century year without a leap day
        '{'{ACT_ADD_DAYS, 16'd1, 5'd28, 4'd2, 14'd1900}, 1'b1,
          '{9'd60, 5'd1, 4'd3, 14'd1900}},
        // last day of a leap year
        '{'{ACT_ADD_DAYS, 16'd0, 5'd31, 4'd12, 14'd2024}, 1'b1,
          '{9'd366, 5'd31, 4'd12, 14'd2024}},
        // year zero counts as leap
        '{'{ACT_ADD_DAYS, 16'd59, 5'd1, 4'd1, 14'd0}, 1'b1, '{9'd60, 5'd29, 4'd2, 14'd0}},
        // year above range saturates
        '{'{ACT_ADD_DAYS, 16'd0, 5'd15, 4'd6, 14'd16383}, 1'b1,
          '{9'd166, 5'd15, 4'd6, 14'd9999}},
        // month zero taken as January
        '{'{ACT_ADD_DAYS, 16'd0, 5'd10, 4'd0, 14'd2001}, 1'b1,
          '{9'd10, 5'd10, 4'd1, 14'd2001}},
        // month above twelve taken as December
        '{'{ACT_ADD_DAYS, 16'd0, 5'd25, 4'd15, 14'd2001}, 1'b1,
          '{9'd359, 5'd25, 4'd12, 14'd2001}},
        // day zero taken as the first
        '{'{ACT_ADD_DAYS, 16'd0, 5'd0, 4'd3, 14'd2001}, 1'b1, '{9'd60, 5'd1, 4'd3, 14'd2001}},
        // start day past February end carries into March
        '{'{ACT_ADD_DAYS, 16'd0, 5'd31, 4'd2, 14'd2001}, 1'b1,
          '{9'd62, 5'd3, 4'd3, 14'd2001}},
        // start day past April end
        '{'{ACT_ADD_DAYS, 16'd0, 5'd31, 4'd4, 14'd2001}, 1'b1,
          '{9'd121, 5'd1, 4'd5, 14'd2001}},
        // day-of-year count zero gives the first of January
        '{'{ACT_FROM_DOY, 16'd0, 5'd7, 4'd9, 14'd2001}, 1'b1, '{9'd1, 5'd1, 4'd1, 14'd2001}},
        // day 366 of a leap year
        '{'{ACT_FROM_DOY, 16'd366, 5'd1, 4'd1, 14'd2024}, 1'b1,
          '{9'd366, 5'd31, 4'd12, 14'd2024}},
        // day 366 of a common year runs into the next
        '{'{ACT_FROM_DOY, 16'd366, 5'd1, 4'd1, 14'd2023}, 1'b1,
          '{9'd1, 5'd1, 4'd1, 14'd2024}},
        // day 60 of a century common year
        '{'{ACT_FROM_DOY, 16'd60, 5'd0, 4'd0, 14'd1900}, 1'b1,
          '{9'd60, 5'd1, 4'd3, 14'd1900}},
        // 2100 has no leap day
        '{'{ACT_ADD_DAYS, 16'd0, 5'd29, 4'd2, 14'd2100}, 1'b1,
          '{9'd60, 5'd1, 4'd3, 14'd2100}},
        // last day of the year range plus one
        '{'{ACT_ADD_DAYS, 16'd1, 5'd31, 4'd12, 14'd9999}, 1'b1,
          '{9'd1, 5'd1, 4'd1, 14'd10000}},
        // ignored month and day at their top values
        '{'{ACT_FROM_DOY, 16'd1, 5'd31, 4'd15, 14'd0}, 1'b1, '{9'd1, 5'd1, 4'd1, 14'd0}},
        // longest walks, checked by the predictor
        '{'{ACT_ADD_DAYS, 16'd65535, 5'd31, 4'd12, 14'd9999}, 1'b0, '0},
        '{'{ACT_FROM_DOY, 16'd65535, 5'd31, 4'd15, 14'd16383}, 1'b0, '0},
        '{'{ACT_ADD_DAYS, 16'd65535, 5'd1, 4'd1, 14'd0}, 1'b0, '0},
        '{'{ACT_FROM_DOY, 16'd65535, 5'd0, 4'd0, 14'd400}, 1'b0, '0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    date_out_t pending_dates [$];
    int        mismatch_count;
    int        items_sent;
    int        burst_left;

    gregorian_date_add_days_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic bit calendar_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned calendar_month_days(int unsigned m, int unsigned y);
        int unsigned lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2) begin
            return calendar_leap(y) ? 29 : 28;
        end
        return lengths[m - 1];
    endfunction

    // Walk month by month until the day number fits, then count the day of year
    function automatic date_out_t predict_date_sum(date_req_t req);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned doy;
        date_out_t   res;
        y = 32'(req.year);
        if (y > 32'(YEAR_MAX)) begin
            y = 32'(YEAR_MAX);
        end
        if (req.action == ACT_ADD_DAYS) begin
            m = (req.month < 4'd1) ? 1 : ((req.month > 4'd12) ? 12 : 32'(req.month));
            d = (req.day < 5'd1) ? 1 : 32'(req.day);
            d = d + 32'(req.cnt);
        end else begin
            m = 1;
            d = (req.cnt == 16'd0) ? 1 : 32'(req.cnt);
        end
        while (d > calendar_month_days(m, y)) begin
            d = d - calendar_month_days(m, y);
            m = m + 1;
            if (m > 12) begin
                m = 1;
                y = y + 1;
            end
        end
        doy = d;
        for (int unsigned i = 1; i < m; i++) begin
            doy = doy + calendar_month_days(i, y);
        end
        res.year  = y[13:0];
        res.month = m[3:0];
        res.day   = d[4:0];
        res.doy   = doy[8:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("tb: %0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offer one request, hold it until the transfer, then pick the next burst or gap
    task automatic send_request(date_req_t req, date_out_t want);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, req.cnt, req.day, req.month, req.year};
        s_tuser  <= req.action;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_dates.push_back(want);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= {1'b0, 39'($urandom()) ^ {7'($urandom()), 32'd0}};
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Reset, directed steps, random requests, then drain
    initial begin
        date_req_t  req;
        date_out_t  want;
        int unsigned sel;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        mismatch_count = 0;
        items_sent     = 0;
        burst_left     = 4;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            req  = DIRECTED_STEPS[i].req;
            want = DIRECTED_STEPS[i].fixed ? DIRECTED_STEPS[i].want : predict_date_sum(req);
            send_request(req, want);
        end

        for (int i = 0; i < NUM_RANDOM; i++) begin
            req.action = $urandom_range(0, 1) ? ACT_FROM_DOY : ACT_ADD_DAYS;
            // years: mostly in range, some at or just past century marks, some above range
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                req.year = 14'($urandom_range(0, 9999));
            end else if (sel < 90) begin
                req.year = 14'($urandom_range(0, 99) * 100 + $urandom_range(0, 4));
            end else begin
                req.year = 14'($urandom_range(0, 16383));
            end
            req.month = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 12))
                                                     : 4'($urandom_range(0, 15));
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                req.day = 5'($urandom_range(1, 28));
            end else if (sel < 85) begin
                req.day = 5'($urandom_range(28, 31));
            end else begin
                req.day = 5'($urandom_range(0, 31));
            end
            // counts: mostly short walks, a few across the whole range
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                req.cnt = 16'($urandom_range(0, 400));
            end else if (sel < 80) begin
                req.cnt = 16'($urandom_range(0, 4000));
            end else if (sel < 92) begin
                req.cnt = 16'($urandom_range(0, 65535));
            end else if (sel < 96) begin
                req.cnt = 16'(65535 - $urandom_range(0, 40));
            end else begin
                req.cnt = 16'($urandom_range(0, 2));
            end
            send_request(req, predict_date_sum(req));
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_dates.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Drive m_tready in segments of differing stall patterns, with one long hold-off
    initial begin
        rx_mode_t mode;
        int       seg_len;
        bit       held_off;
        m_tready = 1'b0;
        held_off = 1'b0;
        @(posedge aresetn);
        forever begin
            mode    = rx_mode_t'($urandom_range(0, 3));
            seg_len = $urandom_range(20, 200);
            repeat (seg_len) begin
                @(negedge aclk);
                case (mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
            if (!held_off && items_sent >= HOLD_AT_ITEM) begin
                held_off = 1'b1;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end
        end
    end

    // Compare each result transfer with the oldest outstanding date
    always @(posedge aclk) begin
        date_out_t got;
        date_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = date_out_t'(m_tdata);
            if (pending_dates.size() == 0) begin
                report_mismatch("unexpected result, year", int'(got.year), -1);
            end else begin
                want = pending_dates.pop_front();
                if (got.year != want.year) begin
                    report_mismatch("out_year", int'(got.year), int'(want.year));
                end
                if (got.month != want.month) begin
                    report_mismatch("out_month", int'(got.month), int'(want.month));
                end
                if (got.day != want.day) begin
                    report_mismatch("out_day", int'(got.day), int'(want.day));
                end
                if (got.doy != want.doy) begin
                    report_mismatch("out_day_of_year", int'(got.doy), int'(want.doy));
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        #200_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
